// ----- hw/rtl/bcf_pkg.sv -----
// Shared types, codes and sizes for the biconnected components finder.
package bcf_pkg;

  localparam int MaxVertices = 1024;
  localparam int MaxEdges    = 4096;
  localparam int MaxMembers  = 2 * MaxVertices;
  localparam int MaxSlots    = 2 * MaxEdges;

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_COMPUTE = 2'd1,
    ACT_FETCH   = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_ACK    = 3'd0,
    KIND_COUNT  = 3'd1,
    KIND_SIZE   = 3'd2,
    KIND_VERTEX = 3'd3,
    KIND_BRIDGE = 3'd4
  } kind_t;

  localparam logic [1:0] MODE_COMPONENTS = 2'd0;
  localparam logic [1:0] MODE_CUTS       = 2'd1;

  localparam logic [1:0] REG_REPORT_MODE  = 2'd0;
  localparam logic [1:0] REG_VERTEX_COUNT = 2'd1;

  // One depth-first walk frame.
  typedef struct packed {
    logic [10:0] vtx;
    logic        pe_valid;
    logic [11:0] pe;
    logic [13:0] pos;
    logic [13:0] lim;
    logic [1:0]  kids;
    logic [10:0] low;
    logic [10:0] disc;
  } frame_t;

  typedef enum logic [5:0] {
    S_IDLE, S_EMIT, S_FETCH_DATA, S_FETCH_SIZE,
    S_CLR,
    S_CNT_E, S_CNT_A, S_CNT_AW, S_CNT_B, S_CNT_BW,
    S_PFX_RD, S_PFX_WR,
    S_FILL_E, S_FILL_A, S_FILL_AW, S_FILL_B, S_FILL_BW,
    S_ROOT, S_ROOT_CHK, S_ROOT_END,
    S_STEP, S_ADJ, S_DISC, S_PUSH1, S_PUSH2, S_POP,
    S_CL_POP, S_CL_MX, S_CL_MY,
    S_SW_RD, S_SW_WR, S_SW_END,
    S_CUT_RD, S_CUT_WR
  } state_t;

endpackage

// ----- hw/rtl/biconnected_components_finder_unit.sv -----
// Biconnected components, cut vertices and bridges engine, top level.
//
//  channel | direction | handshake            | beat contents
//  --------+-----------+----------------------+-------------------------------------------
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in        | in_valid/in_ready    | action, end_a, end_b
//  out     | out       | out_valid/out_ready  | record_kind, first_value, second_value,
//          |           |                      | last_record, edge_overflow
//
// Add and clear beats go straight to the emit state; a fetch of a component size
// needs two reads of the bounds memory. Compute is a memory sequencer: it clears
// the memories, counts the edges per vertex, takes the prefix sum, fills the
// adjacency memory, walks the adjacency slots, pops the stacked edges and sweeps
// the vertices for every component closed, and builds the cut list.
// Reset is synchronous; after reset the graph is empty and the report empty.
// Every input beat yields one output beat; the out register lets the next
// beat be taken while a result waits. Config beats are taken only when idle.
module biconnected_components_finder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [10:0] end_a,
  input  logic [10:0] end_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  record_kind,
  output logic [12:0] first_value,
  output logic [10:0] second_value,
  output logic        last_record,
  output logic        edge_overflow
);

  bcf_pkg::state_t state, state_next;

  // configuration and graph bookkeeping
  logic [1:0]  report_mode;
  logic [10:0] vertex_count;
  logic [12:0] edge_total;
  logic        overflow_seen;
  logic [10:0] comp_total, bridge_total, cut_total;
  logic [11:0] comp_at;

  // report cursor
  logic        rep_started, rep_done;
  logic [10:0] rep_cursor;
  logic [11:0] rep_sub, rep_base, rep_size;

  // pending result
  logic [2:0]  res_kind;
  logic [12:0] res_first;
  logic [10:0] res_second;
  logic        res_last;

  // compute sequencer
  logic [10:0] n, idx, root_v, vclock, fp, sp, w_v, child_v, child_low, ea, eb, mx, my;
  logic [11:0] w_e, at;
  logic [12:0] e_cnt;
  logic [13:0] sum;
  bcf_pkg::frame_t cur, parent;

  // memories
  logic [21:0] edge_mem [bcf_pkg::MaxEdges];
  logic [13:0] start_mem [bcf_pkg::MaxVertices + 2];
  logic [13:0] fcur_mem [bcf_pkg::MaxVertices + 1];
  logic [22:0] adj_mem [bcf_pkg::MaxSlots];
  logic [10:0] disc_mem [bcf_pkg::MaxVertices + 1];
  logic        cut_mem [bcf_pkg::MaxVertices + 1];
  logic        mark_mem [bcf_pkg::MaxVertices + 1];
  bcf_pkg::frame_t frame_mem [bcf_pkg::MaxVertices];
  logic [21:0] pend_mem [bcf_pkg::MaxVertices];
  logic [10:0] memb_mem [bcf_pkg::MaxMembers];
  logic [11:0] bound_mem [bcf_pkg::MaxVertices + 1];
  logic [21:0] bridge_mem [bcf_pkg::MaxVertices];
  logic [10:0] cutl_mem [bcf_pkg::MaxVertices];

  logic        edge_we;   logic [11:0] edge_wa, edge_ra;   logic [21:0] edge_wd, edge_rd;
  logic        start_we;  logic [10:0] start_wa, start_ra; logic [13:0] start_wd, start_rd;
  logic        fcur_we;   logic [10:0] fcur_wa, fcur_ra;   logic [13:0] fcur_wd, fcur_rd;
  logic        adj_we;    logic [12:0] adj_wa, adj_ra;     logic [22:0] adj_wd, adj_rd;
  logic        disc_we;   logic [10:0] disc_wa, disc_ra;   logic [10:0] disc_wd, disc_rd;
  logic        cut_we;    logic [10:0] cut_wa, cut_ra;     logic cut_wd, cut_rd;
  logic        mark_we;   logic [10:0] mark_wa, mark_ra;   logic mark_wd, mark_rd;
  logic        frame_we;  logic [9:0]  frame_wa, frame_ra;
  bcf_pkg::frame_t frame_wd, frame_rd;
  logic        pend_we;   logic [9:0]  pend_wa, pend_ra;   logic [21:0] pend_wd, pend_rd;
  logic        memb_we;   logic [10:0] memb_wa, memb_ra;   logic [10:0] memb_wd, memb_rd;
  logic        bound_we;  logic [10:0] bound_wa, bound_ra; logic [11:0] bound_wd, bound_rd;
  logic        bridge_we; logic [9:0]  bridge_wa, bridge_ra; logic [21:0] bridge_wd, bridge_rd;
  logic        cutl_we;   logic [9:0]  cutl_wa, cutl_ra;   logic [10:0] cutl_wd, cutl_rd;

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    edge_rd <= edge_mem[edge_ra];
    if (start_we) start_mem[start_wa] <= start_wd;
    start_rd <= start_mem[start_ra];
    if (fcur_we) fcur_mem[fcur_wa] <= fcur_wd;
    fcur_rd <= fcur_mem[fcur_ra];
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    adj_rd <= adj_mem[adj_ra];
    if (disc_we) disc_mem[disc_wa] <= disc_wd;
    disc_rd <= disc_mem[disc_ra];
    if (cut_we) cut_mem[cut_wa] <= cut_wd;
    cut_rd <= cut_mem[cut_ra];
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_rd <= mark_mem[mark_ra];
    if (frame_we) frame_mem[frame_wa] <= frame_wd;
    frame_rd <= frame_mem[frame_ra];
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    pend_rd <= pend_mem[pend_ra];
    if (memb_we) memb_mem[memb_wa] <= memb_wd;
    memb_rd <= memb_mem[memb_ra];
    if (bound_we) bound_mem[bound_wa] <= bound_wd;
    bound_rd <= bound_mem[bound_ra];
    if (bridge_we) bridge_mem[bridge_wa] <= bridge_wd;
    bridge_rd <= bridge_mem[bridge_ra];
    if (cutl_we) cutl_mem[cutl_wa] <= cutl_wd;
    cutl_rd <= cutl_mem[cutl_ra];
  end

  // handshakes
  logic in_fire, cfg_fire, out_free;
  assign cfg_ready = (state == bcf_pkg::S_IDLE);
  assign in_ready  = (state == bcf_pkg::S_IDLE) && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || out_ready;

  // decode helpers
  logic        ends_ok, edge_ok, pos_open, push_ok, skip_edge, closes, match_top;
  logic [10:0] rd_a, rd_b, count, fp_m1, fp_m2, sp_m1, n_sat;
  logic [1:0]  kids_inc;
  logic [10:0] low_min;

  assign ends_ok   = (end_a != 11'd0) && (end_a <= 11'(bcf_pkg::MaxVertices)) &&
                     (end_b != 11'd0) && (end_b <= 11'(bcf_pkg::MaxVertices));
  assign rd_a      = edge_rd[21:11];
  assign rd_b      = edge_rd[10:0];
  assign edge_ok   = (rd_a <= n) && (rd_b <= n);
  assign count     = (report_mode == bcf_pkg::MODE_COMPONENTS) ? comp_total :
                     (report_mode == bcf_pkg::MODE_CUTS) ? cut_total : bridge_total;
  assign fp_m1     = fp - 11'd1;
  assign fp_m2     = fp - 11'd2;
  assign sp_m1     = sp - 11'd1;
  assign n_sat     = (vertex_count > 11'(bcf_pkg::MaxVertices)) ?
                     11'(bcf_pkg::MaxVertices) : vertex_count;
  assign pos_open  = (cur.pos < cur.lim);
  assign push_ok   = (disc_rd == 11'd0) && (fp < 11'(bcf_pkg::MaxVertices)) &&
                     (sp < 11'(bcf_pkg::MaxVertices));
  assign skip_edge = cur.pe_valid && (adj_rd[11:0] == cur.pe);
  assign kids_inc  = (cur.kids == 2'd2) ? 2'd2 : cur.kids + 2'd1;
  assign parent    = frame_rd;
  assign closes    = (parent.disc <= child_low);
  assign low_min   = (child_low < parent.low) ? child_low : parent.low;
  assign match_top = (mx == cur.vtx) && (my == child_v);

  // one report record from the read data
  logic [2:0]  fr_kind;
  logic [12:0] fr_first;
  logic [10:0] fr_second, fr_cursor;
  logic [11:0] fr_sub, fr_size;
  logic        fr_last;

  always_comb begin
    fr_kind   = bcf_pkg::KIND_VERTEX;
    fr_first  = 13'd0;
    fr_second = 11'd0;
    fr_cursor = rep_cursor;
    fr_sub    = rep_sub;
    fr_size   = bound_rd - rep_base;
    if (state == bcf_pkg::S_FETCH_SIZE) begin
      fr_kind  = bcf_pkg::KIND_SIZE;
      fr_first = {1'b0, fr_size};
      if (fr_size == 12'd0) fr_cursor = rep_cursor + 11'd1;
      else fr_sub = 12'd1;
    end else if (report_mode == bcf_pkg::MODE_COMPONENTS) begin
      fr_first = {2'b00, memb_rd};
      if ({1'b0, rep_sub} + 13'd1 > {1'b0, rep_size}) begin
        fr_sub    = 12'd0;
        fr_cursor = rep_cursor + 11'd1;
      end else begin
        fr_sub = rep_sub + 12'd1;
      end
    end else if (report_mode == bcf_pkg::MODE_CUTS) begin
      fr_first  = {2'b00, cutl_rd};
      fr_cursor = rep_cursor + 11'd1;
    end else begin
      fr_kind   = bcf_pkg::KIND_BRIDGE;
      fr_first  = {2'b00, bridge_rd[21:11]};
      fr_second = bridge_rd[10:0];
      fr_cursor = rep_cursor + 11'd1;
    end
    fr_last = (fr_cursor >= count);
  end

  // memory port control
  always_comb begin
    edge_we = 1'b0; edge_wa = edge_total[11:0]; edge_wd = {end_a, end_b};
    edge_ra = e_cnt[11:0];
    start_we = 1'b0; start_wa = idx; start_wd = 14'd0; start_ra = idx;
    fcur_we = 1'b0; fcur_wa = idx; fcur_wd = sum; fcur_ra = rd_a;
    adj_we = 1'b0; adj_wa = fcur_rd[12:0]; adj_wd = {eb, e_cnt[11:0]};
    adj_ra = cur.pos[12:0];
    disc_we = 1'b0; disc_wa = idx; disc_wd = 11'd0; disc_ra = root_v;
    cut_we = 1'b0; cut_wa = idx; cut_wd = 1'b0; cut_ra = idx;
    mark_we = 1'b0; mark_wa = idx; mark_wd = 1'b0; mark_ra = idx;
    frame_we = 1'b0; frame_wa = fp_m1[9:0]; frame_ra = fp_m2[9:0];
    frame_wd = cur;
    frame_wd.kids = kids_inc;
    pend_we = 1'b0; pend_wa = sp[9:0]; pend_wd = {cur.vtx, w_v}; pend_ra = sp_m1[9:0];
    memb_we = 1'b0; memb_wa = at[10:0]; memb_wd = idx;
    memb_ra = 11'(rep_base + rep_sub - 12'd1);
    bound_we = 1'b0; bound_wa = 11'd0; bound_wd = 12'd0; bound_ra = rep_cursor;
    bridge_we = 1'b0; bridge_wa = bridge_total[9:0]; bridge_wd = {parent.vtx, child_v};
    bridge_ra = rep_cursor[9:0];
    cutl_we = 1'b0; cutl_wa = cut_total[9:0]; cutl_wd = idx; cutl_ra = rep_cursor[9:0];
    case (state)
      bcf_pkg::S_IDLE: begin
        edge_we = in_fire && (action == bcf_pkg::ACT_ADD) && ends_ok &&
                  (edge_total < 13'(bcf_pkg::MaxEdges));
      end
      bcf_pkg::S_FETCH_DATA: bound_ra = rep_cursor + 11'd1;
      bcf_pkg::S_CLR: begin
        start_we = 1'b1;
        disc_we  = (idx <= 11'(bcf_pkg::MaxVertices));
        cut_we   = disc_we;
        mark_we  = disc_we;
        bound_we = (idx == 11'd0);
      end
      bcf_pkg::S_CNT_A: start_ra = rd_a + 11'd1;
      bcf_pkg::S_CNT_AW: begin
        start_we = 1'b1; start_wa = ea + 11'd1; start_wd = start_rd + 14'd1;
      end
      bcf_pkg::S_CNT_B: start_ra = eb + 11'd1;
      bcf_pkg::S_CNT_BW: begin
        start_we = 1'b1; start_wa = eb + 11'd1; start_wd = start_rd + 14'd1;
      end
      bcf_pkg::S_PFX_RD: start_ra = idx + 11'd1;
      bcf_pkg::S_PFX_WR: begin
        fcur_we  = 1'b1;
        start_we = 1'b1; start_wa = idx + 11'd1; start_wd = sum + start_rd;
      end
      bcf_pkg::S_FILL_AW: begin
        adj_we = 1'b1;
        fcur_we = 1'b1; fcur_wa = ea; fcur_wd = fcur_rd + 14'd1;
      end
      bcf_pkg::S_FILL_B: fcur_ra = eb;
      bcf_pkg::S_FILL_BW: begin
        adj_we = 1'b1; adj_wd = {ea, e_cnt[11:0]};
        fcur_we = 1'b1; fcur_wa = eb; fcur_wd = fcur_rd + 14'd1;
      end
      bcf_pkg::S_ROOT: start_ra = root_v;
      bcf_pkg::S_ROOT_CHK: begin
        disc_we = (disc_rd == 11'd0); disc_wa = root_v; disc_wd = vclock + 11'd1;
        start_ra = root_v + 11'd1;
      end
      bcf_pkg::S_STEP: begin
        cut_we = !pos_open && (fp == 11'd1) && (cur.kids == 2'd2);
        cut_wa = cur.vtx; cut_wd = 1'b1;
      end
      bcf_pkg::S_ADJ: disc_ra = adj_rd[22:12];
      bcf_pkg::S_DISC: begin
        pend_we  = push_ok;
        frame_we = push_ok;
        disc_we  = push_ok; disc_wa = w_v; disc_wd = vclock + 11'd1;
        start_ra = w_v;
      end
      bcf_pkg::S_PUSH1: start_ra = cur.vtx + 11'd1;
      bcf_pkg::S_POP: begin
        bridge_we = closes && (parent.disc < child_low) &&
                    (bridge_total < 11'(bcf_pkg::MaxVertices));
        cut_we = closes && parent.pe_valid; cut_wa = parent.vtx; cut_wd = 1'b1;
      end
      bcf_pkg::S_CL_MX: begin
        mark_we = 1'b1; mark_wa = pend_rd[21:11]; mark_wd = 1'b1;
      end
      bcf_pkg::S_CL_MY: begin
        mark_we = 1'b1; mark_wa = my; mark_wd = 1'b1;
      end
      bcf_pkg::S_SW_WR: begin
        mark_we = mark_rd;
        memb_we = mark_rd && (at < 12'(bcf_pkg::MaxMembers));
      end
      bcf_pkg::S_SW_END: begin
        bound_we = (comp_total < 11'(bcf_pkg::MaxVertices));
        bound_wa = comp_total + 11'd1; bound_wd = at;
      end
      bcf_pkg::S_CUT_WR: cutl_we = cut_rd;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bcf_pkg::S_IDLE: begin
        if (in_fire) begin
          case (action)
            bcf_pkg::ACT_COMPUTE: state_next = bcf_pkg::S_CLR;
            bcf_pkg::ACT_FETCH: begin
              if (rep_done || !rep_started || rep_cursor >= count)
                state_next = bcf_pkg::S_EMIT;
              else
                state_next = bcf_pkg::S_FETCH_DATA;
            end
            default: state_next = bcf_pkg::S_EMIT;
          endcase
        end
      end
      bcf_pkg::S_FETCH_DATA: begin
        if (report_mode == bcf_pkg::MODE_COMPONENTS && rep_sub == 12'd0)
          state_next = bcf_pkg::S_FETCH_SIZE;
        else
          state_next = bcf_pkg::S_EMIT;
      end
      bcf_pkg::S_FETCH_SIZE: state_next = bcf_pkg::S_EMIT;
      bcf_pkg::S_EMIT: if (out_free) state_next = bcf_pkg::S_IDLE;
      bcf_pkg::S_CLR: begin
        if (idx == 11'(bcf_pkg::MaxVertices + 1)) state_next = bcf_pkg::S_CNT_E;
      end
      bcf_pkg::S_CNT_E:
        state_next = (e_cnt == edge_total) ? bcf_pkg::S_PFX_RD : bcf_pkg::S_CNT_A;
      bcf_pkg::S_CNT_A: state_next = edge_ok ? bcf_pkg::S_CNT_AW : bcf_pkg::S_CNT_E;
      bcf_pkg::S_CNT_AW: state_next = bcf_pkg::S_CNT_B;
      bcf_pkg::S_CNT_B: state_next = bcf_pkg::S_CNT_BW;
      bcf_pkg::S_CNT_BW: state_next = bcf_pkg::S_CNT_E;
      bcf_pkg::S_PFX_RD: state_next = (idx > n) ? bcf_pkg::S_FILL_E : bcf_pkg::S_PFX_WR;
      bcf_pkg::S_PFX_WR: state_next = bcf_pkg::S_PFX_RD;
      bcf_pkg::S_FILL_E:
        state_next = (e_cnt == edge_total) ? bcf_pkg::S_ROOT : bcf_pkg::S_FILL_A;
      bcf_pkg::S_FILL_A: state_next = edge_ok ? bcf_pkg::S_FILL_AW : bcf_pkg::S_FILL_E;
      bcf_pkg::S_FILL_AW: state_next = bcf_pkg::S_FILL_B;
      bcf_pkg::S_FILL_B: state_next = bcf_pkg::S_FILL_BW;
      bcf_pkg::S_FILL_BW: state_next = bcf_pkg::S_FILL_E;
      bcf_pkg::S_ROOT: state_next = (root_v > n) ? bcf_pkg::S_CUT_RD : bcf_pkg::S_ROOT_CHK;
      bcf_pkg::S_ROOT_CHK:
        state_next = (disc_rd != 11'd0) ? bcf_pkg::S_ROOT : bcf_pkg::S_ROOT_END;
      bcf_pkg::S_ROOT_END: state_next = bcf_pkg::S_STEP;
      bcf_pkg::S_STEP: begin
        if (pos_open) state_next = bcf_pkg::S_ADJ;
        else if (fp == 11'd1) state_next = bcf_pkg::S_ROOT;
        else state_next = bcf_pkg::S_POP;
      end
      bcf_pkg::S_ADJ: state_next = skip_edge ? bcf_pkg::S_STEP : bcf_pkg::S_DISC;
      bcf_pkg::S_DISC: state_next = push_ok ? bcf_pkg::S_PUSH1 : bcf_pkg::S_STEP;
      bcf_pkg::S_PUSH1: state_next = bcf_pkg::S_PUSH2;
      bcf_pkg::S_PUSH2: state_next = bcf_pkg::S_STEP;
      bcf_pkg::S_POP: state_next = closes ? bcf_pkg::S_CL_POP : bcf_pkg::S_STEP;
      bcf_pkg::S_CL_POP: state_next = (sp == 11'd0) ? bcf_pkg::S_SW_RD : bcf_pkg::S_CL_MX;
      bcf_pkg::S_CL_MX: state_next = bcf_pkg::S_CL_MY;
      bcf_pkg::S_CL_MY: state_next = match_top ? bcf_pkg::S_SW_RD : bcf_pkg::S_CL_POP;
      bcf_pkg::S_SW_RD: state_next = (idx > n) ? bcf_pkg::S_SW_END : bcf_pkg::S_SW_WR;
      bcf_pkg::S_SW_WR: state_next = bcf_pkg::S_SW_RD;
      bcf_pkg::S_SW_END: state_next = bcf_pkg::S_STEP;
      bcf_pkg::S_CUT_RD: state_next = (idx > n) ? bcf_pkg::S_EMIT : bcf_pkg::S_CUT_WR;
      bcf_pkg::S_CUT_WR: state_next = bcf_pkg::S_CUT_RD;
      default: state_next = bcf_pkg::S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == bcf_pkg::S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (state == bcf_pkg::S_EMIT && out_free) begin
      record_kind   <= res_kind;
      first_value   <= res_first;
      second_value  <= res_second;
      last_record   <= res_last;
      edge_overflow <= overflow_seen;
    end
  end

  // control and bookkeeping registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bcf_pkg::S_IDLE;
      report_mode   <= bcf_pkg::MODE_COMPONENTS;
      vertex_count  <= 11'd1;
      edge_total    <= 13'd0;
      overflow_seen <= 1'b0;
      comp_total    <= 11'd0;
      bridge_total  <= 11'd0;
      cut_total     <= 11'd0;
      comp_at       <= 12'd0;
      rep_started   <= 1'b0;
      rep_done      <= 1'b0;
      rep_cursor    <= 11'd0;
      rep_sub       <= 12'd0;
    end else begin
      state <= state_next;
      case (state)
        bcf_pkg::S_IDLE: begin
          if (cfg_fire) begin
            if (cfg_index == bcf_pkg::REG_REPORT_MODE) report_mode <= cfg_data[1:0];
            else if (cfg_index == bcf_pkg::REG_VERTEX_COUNT) vertex_count <= cfg_data;
            rep_started <= 1'b0; rep_done <= 1'b0;
            rep_cursor <= 11'd0; rep_sub <= 12'd0;
          end
          if (in_fire) begin
            case (action)
              bcf_pkg::ACT_ADD: begin
                if (ends_ok) begin
                  if (edge_total < 13'(bcf_pkg::MaxEdges)) edge_total <= edge_total + 13'd1;
                  else overflow_seen <= 1'b1;
                end
              end
              bcf_pkg::ACT_COMPUTE: begin
                comp_total <= 11'd0; bridge_total <= 11'd0; cut_total <= 11'd0;
                comp_at <= 12'd0;
                rep_started <= 1'b0; rep_done <= 1'b0;
                rep_cursor <= 11'd0; rep_sub <= 12'd0;
              end
              bcf_pkg::ACT_FETCH: begin
                if (!rep_done) begin
                  if (!rep_started) begin
                    rep_started <= 1'b1;
                    if (count == 11'd0) rep_done <= 1'b1;
                  end else if (rep_cursor >= count) begin
                    rep_done <= 1'b1;
                  end
                end
              end
              default: begin
                edge_total <= 13'd0; overflow_seen <= 1'b0;
                comp_total <= 11'd0; bridge_total <= 11'd0; cut_total <= 11'd0;
                comp_at <= 12'd0;
                rep_started <= 1'b0; rep_done <= 1'b0;
                rep_cursor <= 11'd0; rep_sub <= 12'd0;
              end
            endcase
          end
        end
        bcf_pkg::S_FETCH_DATA: begin
          if (!(report_mode == bcf_pkg::MODE_COMPONENTS && rep_sub == 12'd0)) begin
            rep_cursor <= fr_cursor; rep_sub <= fr_sub;
            if (fr_last) rep_done <= 1'b1;
          end
        end
        bcf_pkg::S_FETCH_SIZE: begin
          rep_cursor <= fr_cursor; rep_sub <= fr_sub;
          if (fr_last) rep_done <= 1'b1;
        end
        bcf_pkg::S_POP: begin
          if (closes && parent.disc < child_low &&
              bridge_total < 11'(bcf_pkg::MaxVertices))
            bridge_total <= bridge_total + 11'd1;
        end
        bcf_pkg::S_SW_END: begin
          if (comp_total < 11'(bcf_pkg::MaxVertices)) begin
            comp_total <= comp_total + 11'd1;
            comp_at    <= at;
          end
        end
        bcf_pkg::S_CUT_WR: if (cut_rd) cut_total <= cut_total + 11'd1;
        default: ;
      endcase
    end
  end

  // result and walk datapath
  always_ff @(posedge clk) begin
    case (state)
      bcf_pkg::S_IDLE: begin
        res_kind <= bcf_pkg::KIND_ACK; res_first <= 13'd0;
        res_second <= 11'd0; res_last <= 1'b0;
        if (in_fire && action == bcf_pkg::ACT_FETCH) begin
          if (rep_done) begin
            res_last <= 1'b1;
          end else if (!rep_started) begin
            res_kind  <= bcf_pkg::KIND_COUNT;
            res_first <= {2'b00, count};
            res_last  <= (count == 11'd0);
          end else if (rep_cursor >= count) begin
            res_last <= 1'b1;
          end
        end
        n <= n_sat; idx <= 11'd0; e_cnt <= 13'd0; sum <= 14'd0;
        vclock <= 11'd0; root_v <= 11'd1; sp <= 11'd0; fp <= 11'd0;
      end
      bcf_pkg::S_FETCH_DATA: begin
        rep_base <= bound_rd;
        res_kind <= fr_kind; res_first <= fr_first;
        res_second <= fr_second; res_last <= fr_last;
      end
      bcf_pkg::S_FETCH_SIZE: begin
        rep_size <= fr_size;
        res_kind <= fr_kind; res_first <= fr_first;
        res_second <= fr_second; res_last <= fr_last;
      end
      bcf_pkg::S_CLR: idx <= (idx == 11'(bcf_pkg::MaxVertices + 1)) ? 11'd1 : idx + 11'd1;
      bcf_pkg::S_CNT_A, bcf_pkg::S_FILL_A: begin
        ea <= rd_a; eb <= rd_b;
        if (!edge_ok) e_cnt <= e_cnt + 13'd1;
      end
      bcf_pkg::S_CNT_E, bcf_pkg::S_FILL_E:
        if (e_cnt == edge_total) e_cnt <= 13'd0;
      bcf_pkg::S_CNT_BW, bcf_pkg::S_FILL_BW: e_cnt <= e_cnt + 13'd1;
      bcf_pkg::S_PFX_WR: begin
        sum <= sum + start_rd;
        idx <= idx + 11'd1;
      end
      bcf_pkg::S_ROOT: idx <= 11'd1;
      bcf_pkg::S_ROOT_CHK: begin
        if (disc_rd != 11'd0) begin
          root_v <= root_v + 11'd1;
        end else begin
          vclock       <= vclock + 11'd1;
          cur.vtx      <= root_v;
          cur.pe_valid <= 1'b0;
          cur.pe       <= 12'd0;
          cur.pos      <= start_rd;
          cur.kids     <= 2'd0;
          cur.low      <= vclock + 11'd1;
          cur.disc     <= vclock + 11'd1;
        end
      end
      bcf_pkg::S_ROOT_END: begin
        cur.lim <= start_rd;
        fp <= 11'd1;
      end
      bcf_pkg::S_STEP: begin
        if (pos_open) begin
          cur.pos <= cur.pos + 14'd1;
        end else if (fp == 11'd1) begin
          fp <= 11'd0;
          root_v <= root_v + 11'd1;
        end else begin
          fp <= fp_m1;
          child_v <= cur.vtx;
          child_low <= cur.low;
        end
      end
      bcf_pkg::S_ADJ: begin
        w_v <= adj_rd[22:12];
        w_e <= adj_rd[11:0];
      end
      bcf_pkg::S_DISC: begin
        if (disc_rd != 11'd0) begin
          if (disc_rd < cur.low) cur.low <= disc_rd;
        end else if (push_ok) begin
          sp <= sp + 11'd1;
          fp <= fp + 11'd1;
          vclock <= vclock + 11'd1;
          cur.vtx      <= w_v;
          cur.pe_valid <= 1'b1;
          cur.pe       <= w_e;
          cur.kids     <= 2'd0;
          cur.low      <= vclock + 11'd1;
          cur.disc     <= vclock + 11'd1;
        end
      end
      bcf_pkg::S_PUSH1: cur.pos <= start_rd;
      bcf_pkg::S_PUSH2: cur.lim <= start_rd;
      bcf_pkg::S_POP: begin
        cur     <= parent;
        cur.low <= low_min;
        at      <= comp_at;
      end
      bcf_pkg::S_CL_POP: begin
        if (sp != 11'd0) sp <= sp_m1;
        else idx <= 11'd1;
      end
      bcf_pkg::S_CL_MX: begin
        mx <= pend_rd[21:11];
        my <= pend_rd[10:0];
      end
      bcf_pkg::S_CL_MY: if (match_top) idx <= 11'd1;
      bcf_pkg::S_SW_WR: begin
        if (mark_rd && at < 12'(bcf_pkg::MaxMembers)) at <= at + 12'd1;
        idx <= idx + 11'd1;
      end
      bcf_pkg::S_CUT_WR: idx <= idx + 11'd1;
      default: ;
    endcase
  end

endmodule

// ----- tb/biconnected_components_finder_unit_tb.sv -----
// Self-checking testbench for the biconnected components finder unit.
`timescale 1ns / 1ps

module biconnected_components_finder_unit_tb;
  import bcf_pkg::*;

  // Report modes and register indexes that the package leaves unnamed
  localparam logic [1:0] MODE_BRIDGES     = 2'd2;
  localparam logic [1:0] MODE_BRIDGES_ALT = 2'd3;
  localparam logic [1:0] REG_SPARE_A      = 2'd2;
  localparam logic [1:0] REG_SPARE_B      = 2'd3;
  localparam int         NoEdge           = -1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = '0;
  logic [10:0] end_a = '0;
  logic [10:0] end_b = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  record_kind;
  logic [12:0] first_value;
  logic [10:0] second_value;
  logic        last_record;
  logic        edge_overflow;

  biconnected_components_finder_unit u_top (.*);

  always #2 clk = ~clk;

  typedef struct {
    kind_t       kind;
    logic [12:0] first;
    logic [10:0] second;
    logic        last;
    logic        ovf;
  } record_t;

  record_t pending_records[$];
  bit      failed = 1'b0;
  bit      quiet = 1'b0;   // no idling on either side once set
  int      items_sent = 0;

  // ---------------------------------------------------------------------------
  // Graph model: edge store, adjacency, walk state and finished report lists
  // ---------------------------------------------------------------------------
  int unsigned mode_reg, nv_reg;
  int unsigned edge_a[MaxEdges], edge_b[MaxEdges], edge_cnt;
  int unsigned adj_start[MaxVertices + 2];
  int unsigned adj_to[MaxSlots];
  int          adj_id[MaxSlots];
  int unsigned disc[MaxVertices + 1], low[MaxVertices + 1];
  bit          cut_mark[MaxVertices + 1], member[MaxVertices + 1];
  int unsigned fr_v[MaxVertices], fr_pos[MaxVertices], fr_kids[MaxVertices];
  int          fr_pe[MaxVertices];
  int unsigned stk_p[MaxVertices], stk_c[MaxVertices], stk_depth;
  int unsigned members[MaxMembers], bounds[MaxVertices + 1], block_cnt;
  int unsigned br_p[MaxVertices], br_c[MaxVertices], bridge_cnt;
  int unsigned cut_list[MaxVertices], cut_cnt;
  int unsigned tick;
  int unsigned cursor, sub;
  bit          started, done, overflow;

  function void restart_report();
    cursor = 0; sub = 0; started = 0; done = 0;
  endfunction

  function void drop_results();
    block_cnt = 0; bounds[0] = 0; bridge_cnt = 0; cut_cnt = 0;
  endfunction

  // Pop tree edges down to (p,c); the touched vertices, ascending, form one block.
  function void close_block(int unsigned p, int unsigned c, int unsigned n);
    int unsigned at, x, y;
    at = bounds[block_cnt];
    while (stk_depth > 0) begin
      stk_depth--;
      x = stk_p[stk_depth];
      y = stk_c[stk_depth];
      member[x] = 1;
      member[y] = 1;
      if (x == p && y == c) break;
    end
    for (int unsigned v = 1; v <= n; v++) begin
      if (member[v]) begin
        member[v] = 0;
        if (at < MaxMembers) begin
          members[at] = v;
          at++;
        end
      end
    end
    if (block_cnt < MaxVertices) begin
      block_cnt++;
      bounds[block_cnt] = at;
    end
  endfunction

  function void solve_graph();
    int unsigned n, fp, u, w, slot, p, a, b;
    n = (nv_reg > MaxVertices) ? MaxVertices : nv_reg;
    drop_results();
    stk_depth = 0;
    tick = 0;
    for (int i = 0; i <= MaxVertices; i++) begin
      disc[i] = 0; cut_mark[i] = 0; member[i] = 0;
    end
    for (int i = 0; i < MaxVertices + 2; i++) adj_start[i] = 0;
    for (int e = 0; e < edge_cnt; e++) begin
      a = edge_a[e]; b = edge_b[e];
      if (a <= n && b <= n) begin
        adj_start[a + 1]++;
        adj_start[b + 1]++;
      end
    end
    for (int unsigned v = 1; v <= n; v++) adj_start[v + 1] += adj_start[v];
    for (int unsigned v = 1; v <= n; v++) low[v] = adj_start[v];
    // low[] doubles as the fill pointer while building the adjacency lists
    for (int e = 0; e < edge_cnt; e++) begin
      a = edge_a[e]; b = edge_b[e];
      if (a <= n && b <= n) begin
        adj_to[low[a]] = b; adj_id[low[a]] = e; low[a]++;
        adj_to[low[b]] = a; adj_id[low[b]] = e; low[b]++;
      end
    end
    for (int unsigned r = 1; r <= n; r++) begin
      if (disc[r] != 0) continue;
      tick++;
      disc[r] = tick; low[r] = tick;
      fr_v[0] = r; fr_pe[0] = NoEdge; fr_pos[0] = adj_start[r]; fr_kids[0] = 0;
      fp = 1;
      while (fp > 0) begin
        u = fr_v[fp - 1];
        if (fr_pos[fp - 1] < adj_start[u + 1]) begin
          slot = fr_pos[fp - 1];
          fr_pos[fp - 1]++;
          w = adj_to[slot];
          // only the arriving tree edge is skipped; parallel edges are back edges
          if (adj_id[slot] == fr_pe[fp - 1]) continue;
          if (disc[w] != 0) begin
            if (disc[w] < low[u]) low[u] = disc[w];
          end else if (fp < MaxVertices && stk_depth < MaxVertices) begin
            fr_kids[fp - 1]++;
            stk_p[stk_depth] = u; stk_c[stk_depth] = w; stk_depth++;
            tick++;
            disc[w] = tick; low[w] = tick;
            fr_v[fp] = w; fr_pe[fp] = adj_id[slot]; fr_pos[fp] = adj_start[w];
            fr_kids[fp] = 0;
            fp++;
          end
        end else begin
          fp--;
          if (fp == 0) begin
            if (fr_kids[0] > 1) cut_mark[u] = 1;
          end else begin
            p = fr_v[fp - 1];
            if (low[u] < low[p]) low[p] = low[u];
            if (disc[p] <= low[u]) begin
              if (disc[p] < low[u] && bridge_cnt < MaxVertices) begin
                br_p[bridge_cnt] = p; br_c[bridge_cnt] = u; bridge_cnt++;
              end
              if (fr_pe[fp - 1] != NoEdge) cut_mark[p] = 1;
              close_block(p, u, n);
            end
          end
        end
      end
    end
    for (int unsigned v = 1; v <= n; v++)
      if (cut_mark[v]) begin
        cut_list[cut_cnt] = v;
        cut_cnt++;
      end
  endfunction

  function record_t next_record();
    record_t     r;
    int unsigned total, base, size;
    total = (mode_reg == MODE_COMPONENTS) ? block_cnt :
            (mode_reg == MODE_CUTS) ? cut_cnt : bridge_cnt;
    r = '{KIND_ACK, '0, '0, 1'b0, 1'b0};
    if (done) begin
      r.last = 1;
      return r;
    end
    if (!started) begin
      started = 1;
      r.kind = KIND_COUNT;
      r.first = total;
      if (total == 0) begin
        done = 1;
        r.last = 1;
      end
      return r;
    end
    if (cursor >= total) begin
      done = 1;
      r.last = 1;
      return r;
    end
    if (mode_reg == MODE_COMPONENTS) begin
      base = bounds[cursor];
      size = bounds[cursor + 1] - base;
      if (sub == 0) begin
        r.kind = KIND_SIZE;
        r.first = size;
        sub = 1;
        if (size == 0) begin
          sub = 0;
          cursor++;
        end
      end else begin
        r.kind = KIND_VERTEX;
        r.first = members[(base + sub - 1) % MaxMembers];
        sub++;
        if (sub > size) begin
          sub = 0;
          cursor++;
        end
      end
    end else if (mode_reg == MODE_CUTS) begin
      r.kind = KIND_VERTEX;
      r.first = cut_list[cursor];
      cursor++;
    end else begin
      r.kind = KIND_BRIDGE;
      r.first = br_p[cursor];
      r.second = br_c[cursor];
      cursor++;
    end
    if (cursor >= total) begin
      done = 1;
      r.last = 1;
    end
    return r;
  endfunction

  // Advance the model by one input beat and return the record it produces.
  function record_t apply_command(logic [1:0] op, logic [10:0] a, logic [10:0] b);
    record_t r;
    r = '{KIND_ACK, '0, '0, 1'b0, 1'b0};
    case (op)
      ACT_ADD: begin
        if (a >= 1 && a <= MaxVertices && b >= 1 && b <= MaxVertices) begin
          if (edge_cnt < MaxEdges) begin
            edge_a[edge_cnt] = a; edge_b[edge_cnt] = b; edge_cnt++;
          end else begin
            overflow = 1;
          end
        end
      end
      ACT_COMPUTE: begin
        solve_graph();
        restart_report();
      end
      ACT_FETCH: r = next_record();
      default: begin
        edge_cnt = 0;
        overflow = 0;
        drop_results();
        restart_report();
      end
    endcase
    r.ovf = overflow;
    return r;
  endfunction

  function void apply_register(logic [1:0] idx, logic [10:0] data);
    if (idx == REG_REPORT_MODE) mode_reg = data[1:0];
    else if (idx == REG_VERTEX_COUNT) nv_reg = data;
    restart_report();
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: inputs change on the falling edge, handshakes seen on the rising
  // ---------------------------------------------------------------------------
  task automatic send_command(logic [1:0] op, logic [10:0] a, logic [10:0] b,
                              output bit last_seen, input bit typed = 0,
                              input record_t typed_rec = '{KIND_ACK, '0, '0, 1'b0, 1'b0});
    int      gap;
    record_t r;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    action = op;
    end_a = a;
    end_b = b;
    do @(posedge clk); while (!in_ready);
    r = apply_command(op, a, b);
    last_seen = r.last;
    pending_records.push_back(typed ? typed_rec : r);
    items_sent++;
  endtask

  // Block is idle once every result is back; config is only written then.
  task automatic wait_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_records.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [10:0] data);
    wait_results();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic fetch_report(bit extra);
    bit lst;
    lst = 0;
    while (!lst) send_command(ACT_FETCH, $urandom, $urandom, lst);
    if (extra) send_command(ACT_FETCH, $urandom, $urandom, lst);
  endtask

  // Receiver drops out_ready at random, in bursts of random length
  int stall_left = 0;
  always @(negedge clk) begin
    if (quiet) begin
      out_ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Output checker: each beat against the oldest outstanding record
  always @(posedge clk) begin
    record_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_records.size() == 0) begin
        $error("unexpected output beat kind %0d first %0d", record_kind, first_value);
        failed = 1'b1;
      end else begin
        want = pending_records.pop_front();
        if (record_kind !== want.kind) begin
          $error("record_kind expected %0d actual %0d", want.kind, record_kind);
          failed = 1'b1;
        end
        if (first_value !== want.first) begin
          $error("first_value expected %0d actual %0d", want.first, first_value);
          failed = 1'b1;
        end
        if (second_value !== want.second) begin
          $error("second_value expected %0d actual %0d", want.second, second_value);
          failed = 1'b1;
        end
        if (last_record !== want.last) begin
          $error("last_record expected %0d actual %0d", want.last, last_record);
          failed = 1'b1;
        end
        if (edge_overflow !== want.ovf) begin
          $error("edge_overflow expected %0d actual %0d", want.ovf, edge_overflow);
          failed = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. cfg rows carry the register index in op and data in a.
  // Rows with typed set carry a hand-written expected record.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit          cfg;
    logic [1:0]  op;
    logic [10:0] a, b;
    bit          typed;
    kind_t       kind;
    logic [12:0] first;
    logic        last;
  } row_t;

  row_t directed_rows[] = '{
    // empty graph right after reset: count 0, then the past-the-end ack
    '{0, ACT_FETCH,   0,    0,    1, KIND_COUNT, 0, 1},
    '{0, ACT_FETCH,   0,    0,    1, KIND_ACK,   0, 1},
    // endpoints out of range are dropped silently
    '{0, ACT_ADD,     0,    5,    1, KIND_ACK,   0, 0},
    '{0, ACT_ADD,     1025, 1,    1, KIND_ACK,   0, 0},
    '{0, ACT_ADD,     2047, 2047, 1, KIND_ACK,   0, 0},
    '{0, ACT_COMPUTE, 0,    0,    1, KIND_ACK,   0, 0},
    '{1, REG_VERTEX_COUNT, 6, 0,  0, KIND_ACK,   0, 0},
    // triangle, bridge 3-4, self loop, parallel pair 4-5, edges above n
    '{0, ACT_ADD,     1,    2,    0, KIND_ACK,   0, 0},
    '{0, ACT_ADD,     2,    3,    0, KIND_ACK,   0, 0},
    '{0, ACT_ADD,     3,    1,    0, KIND_ACK,   0, 0},
    '{0, ACT_ADD,     3,    4,    0, KIND_ACK,   0, 0},
    '{0, ACT_ADD,     4,    4,    0, KIND_ACK,   0, 0},
    '{0, ACT_ADD,     4,    5,    0, KIND_ACK,   0, 0},
    '{0, ACT_ADD,     5,    4,    0, KIND_ACK,   0, 0},
    '{0, ACT_ADD,     6,    7,    0, KIND_ACK,   0, 0},
    '{0, ACT_ADD,     1024, 1024, 0, KIND_ACK,   0, 0},
    '{0, ACT_COMPUTE, 0,    0,    0, KIND_ACK,   0, 0},
    '{0, ACT_FETCH,   0,    0,    0, KIND_ACK,   0, 0},
    '{0, ACT_FETCH,   0,    0,    0, KIND_ACK,   0, 0},
    '{1, REG_REPORT_MODE, MODE_CUTS, 0, 0, KIND_ACK, 0, 0},
    '{0, ACT_FETCH,   0,    0,    0, KIND_ACK,   0, 0},
    '{1, REG_REPORT_MODE, MODE_BRIDGES_ALT, 0, 0, KIND_ACK, 0, 0},
    '{0, ACT_FETCH,   0,    0,    0, KIND_ACK,   0, 0},
    '{0, ACT_FETCH,   0,    0,    0, KIND_ACK,   0, 0},
    '{1, REG_SPARE_A, 0,    0,    0, KIND_ACK,   0, 0},
    '{0, ACT_FETCH,   0,    0,    0, KIND_ACK,   0, 0},
    // clear wipes edges and results
    '{0, ACT_CLEAR,   0,    0,    1, KIND_ACK,   0, 0},
    '{0, ACT_FETCH,   0,    0,    1, KIND_COUNT, 0, 1}
  };

  function automatic logic [10:0] pick_end(int unsigned span);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r <= 2) return $urandom;   // full 11-bit noise, mostly dropped
    return $urandom_range(1, span + 1);  // span + 1 is above n
  endfunction

  initial begin
    bit          lst;
    int          phase, k, sel;
    int unsigned span;
    logic [10:0] nv;

    mode_reg = 0; nv_reg = 1; edge_cnt = 0; overflow = 0; tick = 0;
    for (int i = 0; i <= MaxVertices; i++) begin
      disc[i] = 0; cut_mark[i] = 0; member[i] = 0;
    end
    drop_results();
    restart_report();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg)
        write_register(directed_rows[i].op, directed_rows[i].a);
      else
        send_command(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b, lst,
                     directed_rows[i].typed,
                     '{directed_rows[i].kind, directed_rows[i].first, '0,
                       directed_rows[i].last, 1'b0});
    end

    // Overflow: fill the edge store past capacity on a small graph
    write_register(REG_VERTEX_COUNT, 8);
    write_register(REG_REPORT_MODE, MODE_COMPONENTS);
    quiet = 1'b1;
    for (int i = 0; i < MaxEdges + 3; i++)
      send_command(ACT_ADD, $urandom_range(1, 8), $urandom_range(1, 8), lst);
    quiet = 1'b0;
    send_command(ACT_COMPUTE, 0, 0, lst);
    fetch_report(1);
    send_command(ACT_CLEAR, 0, 0, lst);

    // Random graphs: mostly small, a few at the size extremes
    phase = 0;
    while (items_sent < MaxEdges + 560) begin
      sel = $urandom_range(0, 11);
      case (sel)
        0: nv = 1;
        1: nv = MaxVertices;
        2: nv = 0;
        3: nv = 11'd2047;
        4: nv = $urandom_range(13, 60);
        default: nv = $urandom_range(2, 12);
      endcase
      write_register(REG_VERTEX_COUNT, nv);
      write_register(REG_REPORT_MODE, $urandom_range(0, 3));
      if ($urandom_range(0, 5) == 0) write_register($urandom_range(2, 3), $urandom);
      send_command(ACT_CLEAR, $urandom, $urandom, lst);
      span = (nv == 0) ? 1 : (nv > MaxVertices) ? MaxVertices : nv;
      k = $urandom_range(0, (span < 10) ? 3 * span + 2 : 30);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 24) == 0)
          send_command($urandom, $urandom, $urandom, lst);  // stray command
        else if (span > 3 && $urandom_range(0, 3) == 0)
          send_command(ACT_ADD, i % span + 1, (i + 1) % span + 1, lst);  // path/cycle
        else
          send_command(ACT_ADD, pick_end(span), pick_end(span), lst);
      end
      if (phase == 2) wait_results();  // hold off until all results are back
      send_command(ACT_COMPUTE, $urandom, $urandom, lst);
      fetch_report($urandom_range(0, 1));
      if ($urandom_range(0, 1) == 0) begin
        write_register(REG_REPORT_MODE, $urandom_range(0, 3));
        fetch_report($urandom_range(0, 1));
      end
      phase++;
      if (items_sent >= MaxEdges + 480) quiet = 1'b1;
    end

    wait_results();
    repeat (50) @(posedge clk);
    if (!failed)
      $display("biconnected_components_finder_unit_tb passed");
    else
      $display("biconnected_components_finder_unit_tb failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("biconnected_components_finder_unit_tb failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/bcf_pkg.sv
hw/rtl/biconnected_components_finder_unit.sv
tb/biconnected_components_finder_unit_tb.sv
